/* sv/voxel_face_mesher_defines.svh */
// Assertion macros used by the mesher RTL.
`ifndef VOXEL_FACE_MESHER_DEFINES_SVH
`define VOXEL_FACE_MESHER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define VFM_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define VFM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/vfm_pkg.sv */
`timescale 1ns / 1ps

package vfm_pkg;

    localparam int FACE_COUNT = 6;
    localparam int CORNER_COUNT = 6;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EMIT = 1'b1;

    localparam logic [2:0] FACE_ZN = 3'd0;
    localparam logic [2:0] FACE_ZP = 3'd1;
    localparam logic [2:0] FACE_XP = 3'd2;
    localparam logic [2:0] FACE_XN = 3'd3;
    localparam logic [2:0] FACE_YN = 3'd4;
    localparam logic [2:0] FACE_YP = 3'd5;

    localparam logic [2:0] LAST_CORNER = 3'd5;
    localparam logic [2:0] LOOKUP_LAST = 3'd6;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EMIT
    } state_t;

    // corner offsets packed as {dx, dy, dz}, per face, in emission order
    localparam logic [2:0] CORNER_TABLE [FACE_COUNT][CORNER_COUNT] = '{
        '{3'd0, 3'd2, 3'd4, 3'd6, 3'd4, 3'd2},
        '{3'd1, 3'd5, 3'd3, 3'd7, 3'd3, 3'd5},
        '{3'd7, 3'd4, 3'd6, 3'd7, 3'd5, 3'd4},
        '{3'd3, 3'd2, 3'd0, 3'd3, 3'd0, 3'd1},
        '{3'd5, 3'd1, 3'd4, 3'd0, 3'd4, 3'd1},
        '{3'd7, 3'd6, 3'd3, 3'd2, 3'd3, 3'd6}
    };

    function automatic logic [2:0] first_set(input logic [FACE_COUNT-1:0] mask);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = FACE_COUNT - 1; i >= 0; i--)
        begin
            if (mask[i])
            begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* sv/vfm_ram.sv */
`timescale 1ns / 1ps

module vfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* sv/voxel_face_mesher.sv */
// Voxel face mesher: a cubic store of block bytes with face-culled vertex output.
// Input channel (in_valid/in_ready): command 0 writes block_value at
// (cell_x, cell_y, cell_z); command 1 emits the exposed faces of that voxel.
// Output channel (out_valid/out_ready): one corner vertex per transfer, six per
// exposed face in the order z-1, z+1, x+1, x-1, y-1, y+1; last_vertex marks the
// final vertex of a voxel. Air, enclosed or out-of-grid voxels give no vertices.
// A write goes into the store in the cycle it is accepted. An emit is accepted,
// then reads the center voxel and its six neighbours in turn through the single
// registered read port of the store, then gives one vertex per cycle while
// out_ready is high. One item is worked at a time; in_ready is high only
// while the block is idle.
// After reset the block runs a clearing pass over the store, one entry per
// cycle (4096 entries at the default grid), with in_ready low.
// When the receiver stalls, the current vertex holds on the output ports and
// the block waits; nothing is dropped.
`timescale 1ns / 1ps
`include "voxel_face_mesher_defines.svh"

module voxel_face_mesher #(
    parameter int GRID_SIZE = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [3:0] cell_x,
    input  logic [3:0] cell_y,
    input  logic [3:0] cell_z,
    input  logic [7:0] block_value,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] vertex_x,
    output logic [4:0] vertex_y,
    output logic [4:0] vertex_z,
    output logic [7:0] block_code,
    output logic [2:0] face_id,
    output logic       last_vertex
);

    localparam int EFF = (GRID_SIZE < 16) ? GRID_SIZE : 16;
    localparam int CW = $clog2(EFF);
    localparam int AW = 3 * CW;
    localparam int DEPTH = 1 << AW;
    localparam logic [4:0] EFF5 = 5'(EFF);

    vfm_pkg::state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [2:0]    idx_reg, idx_next;
    logic [5:0]    expose_reg, expose_next;
    logic [2:0]    face_reg, face_next;
    logic [2:0]    corner_reg, corner_next;
    logic [3:0]    x_reg, x_next;
    logic [3:0]    y_reg, y_next;
    logic [3:0]    z_reg, z_next;
    logic [7:0]    block_reg, block_next;

    logic          in_accept;
    logic          in_range;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic [4:0]    xe, ye, ze, xm, xp, ym, yp, zm, zp;
    logic [5:0]    outside;
    logic          hit;
    logic [5:0]    expose_step;
    logic [5:0]    above;
    logic [2:0]    cofs;

    function automatic logic [AW-1:0] cell_addr(input logic [4:0] ax, input logic [4:0] ay,
                                                input logic [4:0] az);
        return {ax[CW-1:0], ay[CW-1:0], az[CW-1:0]};
    endfunction

    assign in_ready  = (state_reg == vfm_pkg::ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign in_range  = ({1'b0, cell_x} < EFF5) && ({1'b0, cell_y} < EFF5)
                       && ({1'b0, cell_z} < EFF5);

    assign xe = {1'b0, x_reg};
    assign ye = {1'b0, y_reg};
    assign ze = {1'b0, z_reg};
    assign xm = xe - 5'd1;
    assign xp = xe + 5'd1;
    assign ym = ye - 5'd1;
    assign yp = ye + 5'd1;
    assign zm = ze - 5'd1;
    assign zp = ze + 5'd1;

    assign outside[vfm_pkg::FACE_ZN] = (z_reg == 4'd0);
    assign outside[vfm_pkg::FACE_ZP] = (zp >= EFF5);
    assign outside[vfm_pkg::FACE_XP] = (xp >= EFF5);
    assign outside[vfm_pkg::FACE_XN] = (x_reg == 4'd0);
    assign outside[vfm_pkg::FACE_YN] = (y_reg == 4'd0);
    assign outside[vfm_pkg::FACE_YP] = (yp >= EFF5);

    // store write port: clearing pass or a write command
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = cell_addr({1'b0, cell_x}, {1'b0, cell_y}, {1'b0, cell_z});
        mem_wdata = block_value;
        if (state_reg == vfm_pkg::ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = 8'd0;
        end
        else if (in_accept && command == vfm_pkg::CMD_WRITE && in_range)
        begin
            mem_we = 1'b1;
        end
    end

    // store read port: center on accept, then one neighbour per lookup cycle until all six are read
    always_comb
    begin
        if (state_reg == vfm_pkg::ST_LOOKUP)
        begin
            unique case (idx_reg)
                vfm_pkg::FACE_ZN: mem_raddr = cell_addr(xe, ye, zm);
                vfm_pkg::FACE_ZP: mem_raddr = cell_addr(xe, ye, zp);
                vfm_pkg::FACE_XP: mem_raddr = cell_addr(xp, ye, ze);
                vfm_pkg::FACE_XN: mem_raddr = cell_addr(xm, ye, ze);
                vfm_pkg::FACE_YN: mem_raddr = cell_addr(xe, ym, ze);
                vfm_pkg::FACE_YP: mem_raddr = cell_addr(xe, yp, ze);
                default:          mem_raddr = cell_addr(xe, ye, ze);
            endcase
        end
        else
        begin
            mem_raddr = cell_addr({1'b0, cell_x}, {1'b0, cell_y}, {1'b0, cell_z});
        end
    end

    vfm_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign hit         = (mem_rdata == 8'd0) || outside[idx_reg - 3'd1];
    assign expose_step = expose_reg | (6'(hit) << (idx_reg - 3'd1));
    assign above       = expose_reg & (6'b111110 << face_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vfm_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = vfm_pkg::ST_IDLE;
                end
            end
            vfm_pkg::ST_IDLE:
            begin
                if (in_accept && command == vfm_pkg::CMD_EMIT && in_range)
                begin
                    state_next = vfm_pkg::ST_LOOKUP;
                end
            end
            vfm_pkg::ST_LOOKUP:
            begin
                if (idx_reg == vfm_pkg::LOOKUP_LAST)
                begin
                    if (block_reg != 8'd0 && expose_step != 6'd0)
                    begin
                        state_next = vfm_pkg::ST_EMIT;
                    end
                    else
                    begin
                        state_next = vfm_pkg::ST_IDLE;
                    end
                end
            end
            vfm_pkg::ST_EMIT:
            begin
                if (out_ready && last_vertex)
                begin
                    state_next = vfm_pkg::ST_IDLE;
                end
            end
            default: state_next = vfm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        clr_next    = clr_reg;
        idx_next    = idx_reg;
        expose_next = expose_reg;
        face_next   = face_reg;
        corner_next = corner_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        z_next      = z_reg;
        block_next  = block_reg;
        unique case (state_reg)
            vfm_pkg::ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
            end
            vfm_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    x_next      = cell_x;
                    y_next      = cell_y;
                    z_next      = cell_z;
                    idx_next    = 3'd0;
                    expose_next = 6'd0;
                end
            end
            vfm_pkg::ST_LOOKUP:
            begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'd0)
                begin
                    block_next = mem_rdata;
                end
                else
                begin
                    expose_next = expose_step;
                end
                if (idx_reg == vfm_pkg::LOOKUP_LAST)
                begin
                    face_next   = vfm_pkg::first_set(expose_step);
                    corner_next = 3'd0;
                end
            end
            vfm_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    if (corner_reg == vfm_pkg::LAST_CORNER)
                    begin
                        corner_next = 3'd0;
                        face_next   = vfm_pkg::first_set(above);
                    end
                    else
                    begin
                        corner_next = corner_reg + 3'd1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= vfm_pkg::ST_CLEAR;
            clr_reg    <= '0;
            idx_reg    <= 3'd0;
            expose_reg <= 6'd0;
            face_reg   <= 3'd0;
            corner_reg <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            idx_reg    <= idx_next;
            expose_reg <= expose_next;
            face_reg   <= face_next;
            corner_reg <= corner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        block_reg <= block_next;
    end

    assign cofs        = vfm_pkg::CORNER_TABLE[face_reg][corner_reg];
    assign out_valid   = (state_reg == vfm_pkg::ST_EMIT);
    assign vertex_x    = xe + {4'd0, cofs[2]};
    assign vertex_y    = ye + {4'd0, cofs[1]};
    assign vertex_z    = ze + {4'd0, cofs[0]};
    assign block_code  = block_reg;
    assign face_id     = face_reg;
    assign last_vertex = (corner_reg == vfm_pkg::LAST_CORNER) && (above == 6'd0);

    `VFM_ASSERT_SAME(a_no_overlap, out_valid, !in_ready, "input taken during emission")
    `VFM_ASSERT_SAME(a_face_exposed, out_valid, expose_reg[face_reg], "vertex of hidden face")
    `VFM_ASSERT_NEXT(a_last_ends, out_valid && out_ready && last_vertex, in_ready,
                     "block not idle after last vertex")
    `VFM_ASSERT_NEXT(a_more_follow, out_valid && out_ready && !last_vertex, out_valid,
                     "emission stopped before last vertex")

endmodule
